### rtl/core/rpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants
// Register indexes, reset values and the item, result and config records.
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_MS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_INTERVAL_MS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_LOW       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_HIGH      = 3'd6;

   localparam logic        RST_ENABLE          = 1'b1;
   localparam logic [15:0] RST_MAG_THRESHOLD   = 16'd3072;
   localparam logic [31:0] RST_WINDOW_MS       = 32'd60000;
   localparam logic [7:0]  RST_COUNT_LIMIT     = 8'd5;
   localparam logic [31:0] RST_MIN_INTERVAL_MS = 32'd300000;
   localparam logic [7:0]  RST_ANGLE_LOW       = 8'd0;
   localparam logic [7:0]  RST_ANGLE_HIGH      = 8'd90;

   localparam logic       KIND_SAMPLE = 1'b0;
   localparam logic       KIND_MANUAL = 1'b1;
   localparam logic [7:0] COUNT_MAX   = 8'd255;

   typedef struct packed {
      logic        enable;
      logic [15:0] mag_threshold;
      logic [31:0] window_ms;
      logic [7:0]  count_limit;
      logic [31:0] min_interval_ms;
      logic [7:0]  angle_low;
      logic [7:0]  angle_high;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] time_ms;
      logic [15:0] magnitude;
   } item_type;

   typedef struct packed {
      logic [7:0] motion_tally;
      logic       moved;
      logic       adjusted;
      logic [7:0] pillow_angle;
   } result_type;

endpackage
`default_nettype wire

### rtl/core/rpt_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_csr: configuration registers
// Write-only register file; writes land on the edge with the enable high.
// ----------------------------------------------------------------------------
module rpt_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rpt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rpt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rpt_pkg::cfg_type                       cfg
);

   rpt_pkg::cfg_type cfg_ff;
   rpt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rpt_pkg::REG_ENABLE:          cfg_in.enable          = csr_wdata[0];
            rpt_pkg::REG_MAG_THRESHOLD:   cfg_in.mag_threshold   = csr_wdata[15:0];
            rpt_pkg::REG_WINDOW_MS:       cfg_in.window_ms       = csr_wdata[31:0];
            rpt_pkg::REG_COUNT_LIMIT:     cfg_in.count_limit     = csr_wdata[7:0];
            rpt_pkg::REG_MIN_INTERVAL_MS: cfg_in.min_interval_ms = csr_wdata[31:0];
            rpt_pkg::REG_ANGLE_LOW:       cfg_in.angle_low       = csr_wdata[7:0];
            rpt_pkg::REG_ANGLE_HIGH:      cfg_in.angle_high      = csr_wdata[7:0];
            default: ; // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= rpt_pkg::RST_ENABLE;
         cfg_ff.mag_threshold   <= rpt_pkg::RST_MAG_THRESHOLD;
         cfg_ff.window_ms       <= rpt_pkg::RST_WINDOW_MS;
         cfg_ff.count_limit     <= rpt_pkg::RST_COUNT_LIMIT;
         cfg_ff.min_interval_ms <= rpt_pkg::RST_MIN_INTERVAL_MS;
         cfg_ff.angle_low       <= rpt_pkg::RST_ANGLE_LOW;
         cfg_ff.angle_high      <= rpt_pkg::RST_ANGLE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/core/rpt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_core: restlessness state and update logic
// Holds count, window start, last adjust time and angle; computes one
// transaction's result and next state in a single pass.
// ----------------------------------------------------------------------------
module rpt_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  rpt_pkg::item_type         item,
   input  rpt_pkg::cfg_type          cfg,
   output rpt_pkg::result_type       result
);

   logic [7:0]  count_ff,        count_in;
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] last_adjust_ff,  last_adjust_in;
   logic [7:0]  angle_ff,        angle_in;

   logic        active;
   logic        is_sample;
   logic [31:0] win_elapsed;
   logic [31:0] adj_elapsed;
   logic        expire;
   logic        moved;
   logic [7:0]  count_base;
   logic [7:0]  count_inc;
   logic        auto_toggle;
   logic        toggle;
   logic [7:0]  angle_toggled;

   always_comb begin
      active      = cfg.enable;
      is_sample   = (item.kind == rpt_pkg::KIND_SAMPLE);
      win_elapsed = item.time_ms - window_start_ff;
      adj_elapsed = item.time_ms - last_adjust_ff;
      expire      = active && is_sample && (win_elapsed > cfg.window_ms);
      count_base  = expire ? 8'd0 : count_ff;
      moved       = active && is_sample && (item.magnitude > cfg.mag_threshold);
      if (!moved) begin
         count_inc = count_base;
      end else if (count_base == rpt_pkg::COUNT_MAX) begin
         count_inc = rpt_pkg::COUNT_MAX;
      end else begin
         count_inc = count_base + 8'd1;
      end
      auto_toggle = moved && (count_inc >= cfg.count_limit)
                    && (adj_elapsed > cfg.min_interval_ms);
      toggle      = (active && !is_sample) || auto_toggle;
      angle_toggled = (angle_ff == cfg.angle_low) ? cfg.angle_high : cfg.angle_low;

      count_in        = toggle ? 8'd0 : count_inc;
      angle_in        = toggle ? angle_toggled : angle_ff;
      window_start_in = expire ? item.time_ms : window_start_ff;
      last_adjust_in  = toggle ? item.time_ms : last_adjust_ff;

      result.pillow_angle = angle_in;
      result.adjusted     = toggle;
      result.moved        = moved;
      result.motion_tally = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= 8'd0;
         window_start_ff <= 32'd0;
         last_adjust_ff  <= 32'd0;
         angle_ff        <= rpt_pkg::RST_ANGLE_LOW;
      end else if (fire) begin
         count_ff        <= count_in;
         window_start_ff <= window_start_in;
         last_adjust_ff  <= last_adjust_in;
         angle_ff        <= angle_in;
      end
   end

   // a toggle always leaves the count cleared
   a_toggle_clears: assert property (@(posedge clock) disable iff (reset)
      fire && toggle |=> count_ff == 8'd0)
      else $error("count not cleared after toggle");

   // disabled transactions leave all state alone
   a_disabled_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.enable |=> $stable(count_ff) && $stable(angle_ff)
         && $stable(window_start_ff) && $stable(last_adjust_ff))
      else $error("state changed while disabled");

   // manual requests never report a movement
   a_manual_no_move: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == rpt_pkg::KIND_MANUAL |-> !moved)
      else $error("manual request flagged as movement");

   // any toggle, manual or automatic, stamps the adjustment time with the transaction time
   a_adjust_stamp: assert property (@(posedge clock) disable iff (reset)
      fire && toggle |=> last_adjust_ff == $past(item.time_ms))
      else $error("adjust time not stored");

endmodule
`default_nettype wire

### rtl/core/restlessness_pillow_toggler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// restlessness_pillow_toggler: restlessness-driven pillow angle control
// Counts motion samples above a threshold inside a time window and toggles the pillow
// angle at the count limit once the minimum interval has passed; manual requests toggle now.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while req_tready is high and
// returns exactly one result transaction for each, passing it through the
// input register and then the result register. The state update (window,
// count, angle, adjust time) is a single combinational pass between those
// two registers, so back-to-back transactions see each other's effects with
// no bubble. req_tready falls only when both registers are full and
// rsp_tready is low. Configuration registers are write only and should be
// changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module restlessness_pillow_toggler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [47:0]                      req_tdata,  // time_ms[31:0], magnitude[47:32]
   input  wire logic                             req_tuser,  // kind (0 sample, 1 manual)
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [23:0]                           rsp_tdata,  // pillow_angle[7:0], adjusted[8],
                                                             // moved[9], motion_tally[17:10],
                                                             // zero [23:18]
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [rpt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rpt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rpt_pkg::cfg_type    cfg;
   rpt_pkg::item_type   item_ff, item_in;
   rpt_pkg::result_type rsp_ff, rsp_in;
   logic                in_vld_ff, in_vld_in;
   logic                out_vld_ff, out_vld_in;
   logic                advance;   // input stage moves into result register
   logic                req_take;
   logic                rsp_take;

   rpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (rsp_in)
   );

   always_comb begin
      rsp_take   = out_vld_ff && rsp_tready;
      advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
      req_tready = !in_vld_ff || advance;
      req_take   = req_tvalid && req_tready;

      item_in.kind      = req_tuser;
      item_in.time_ms   = req_tdata[31:0];
      item_in.magnitude = req_tdata[47:32];

      in_vld_in  = req_take || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && !rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.motion_tally, rsp_ff.moved,
                        rsp_ff.adjusted, rsp_ff.pillow_angle};

endmodule
`default_nettype wire
